@@ design/ictf_pkg.sv @@
// Package with constants, types and tables for the complementary tilt filter.
`default_nettype none
package ictf_pkg;
    localparam int unsigned DataWidth    = 16;
    localparam int unsigned DtWidth      = 10;
    localparam int unsigned TempWidth    = 9;
    localparam int unsigned CordicDef    = 16;
    localparam int unsigned CordicMax    = 24;
    localparam logic [15:0] BlendDefault = 16'd62587;

    // Arctangent table in 1/65536 degree, rounded.
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ design/ictf_if.sv @@
// Valid/ready channel interfaces for sample and result words.
`default_nettype none
interface ictf_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] temp_raw;
    logic [9:0] elapsed_ms;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    temp_raw, elapsed_ms, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  temp_raw, elapsed_ms, output ready);
endinterface

interface ictf_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    logic signed [15:0] tilt_z;
    logic signed [8:0]  temp_deg;
    modport source (output valid, tilt_x, tilt_y, tilt_z, temp_deg, input ready);
    modport sink (input valid, tilt_x, tilt_y, tilt_z, temp_deg, output ready);
endinterface
`default_nettype wire

@@ design/ictf_serial_mac.sv @@
// Bit-serial signed multiply-accumulate: acc += a * b, one multiplier bit per cycle.
`default_nettype none
module ictf_serial_mac #(
    parameter int unsigned AW = 32,
    parameter int unsigned BW = 17,
    parameter int unsigned PW = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    input  wire logic signed [PW-1:0] i_acc,
    output logic                      o_done,
    output logic signed [PW-1:0]      o_acc
);
    localparam int unsigned CW = $clog2(BW + 1);

    logic signed [PW-1:0] r_a, n_a;
    logic [BW-1:0]        r_b, n_b;
    logic signed [PW-1:0] r_acc, n_acc;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    // Shift-and-add; the top multiplier bit carries negative weight.
    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_a = PW'(i_a); n_b = i_b; n_acc = i_acc;
            n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                if (r_cnt == CW'(BW - 1)) n_acc = r_acc - r_a;
                else n_acc = r_acc + r_a;
            end
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(BW - 1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule
`default_nettype wire

@@ design/imu_complementary_tilt_filter.sv @@
// Top level of the complementary tilt filter.
// Channel  | Dir | Contents
// i_samp   | in  | six raw axes, raw temperature, elapsed ms
// o_res    | out | three fused tilts, temperature in degrees
// i_cfg_*  | in  | blend weight write
// One word is processed at a time. Per axis: a setup step, one CORDIC iteration
// per cycle (CORDIC_STEPS, capped at CordicMax), a rounding step, two bit-serial
// multiplies, a 22-step quotient loop and a write-back step. An 8-step temperature
// divide, the load into the output register and the return to idle follow. The
// serial multiplies and the quotient loop take most of the time that a word needs.
// Reset sets the weight to its default and clears the angles; a finished result
// waits in the output register while the next sample is worked on, and the block
// holds in its last state only while an earlier result is still unread.
`default_nettype none
module imu_complementary_tilt_filter #(
    parameter int unsigned CORDIC_STEPS = ictf_pkg::CordicDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ictf_in_if.sink          i_samp,
    ictf_out_if.source       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);
    import ictf_pkg::*;

    localparam int unsigned Steps = (CORDIC_STEPS > CordicMax) ? CordicMax : CORDIC_STEPS;
    localparam int unsigned DivTop = 21;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CORD, S_ROUND, S_MUL1, S_MUL1W, S_MUL2, S_MUL2W,
        S_DIV, S_NEXT, S_TEMP, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_w;
    logic signed [15:0] r_ang [3];
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz, r_tr;
    logic [9:0] r_dt;
    logic [1:0] r_axis;
    logic signed [26:0] r_x, r_y;
    logic signed [29:0] r_z;
    logic [4:0] r_i;
    logic signed [15:0] r_acc_ang;
    logic signed [63:0] r_total;
    logic signed [63:0] r_rem;
    logic signed [36:0] r_q;
    logic [5:0] r_dcnt;
    logic signed [19:0] r_tnum;
    logic r_tneg;
    logic signed [8:0] r_tq;
    logic signed [15:0] r_res [3];
    logic signed [8:0] r_tdeg;
    logic r_ovalid;

    // Operand selection for the current axis.
    logic signed [15:0] num, den, gyro, ang;
    always_comb begin
        case (r_axis)
            2'd0: begin num = r_ay; den = r_az; gyro = r_gx; ang = r_ang[0]; end
            2'd1: begin num = r_ax; den = r_az; gyro = r_gy; ang = r_ang[1]; end
            default: begin num = r_ax; den = r_ay; gyro = r_gz; ang = r_ang[2]; end
        endcase
    end

    // Serial multiplier operands: w*P then (65536-w)*A.
    logic signed [31:0] p_val, a_val;
    logic signed [17:0] w_s, wc_s;
    assign p_val = 32'(ang) * 32'sd4125 + 32'(gyro) * 32'($signed({1'b0, r_dt})) * 32'sd32;
    assign a_val = 32'(r_acc_ang) * 32'sd4125;
    assign w_s  = $signed({2'b00, r_w});
    assign wc_s = 18'sd65536 - w_s;

    logic mac_start, mac_done;
    logic signed [31:0] mac_a;
    logic signed [17:0] mac_b;
    logic signed [63:0] mac_acc, mac_out;
    assign mac_start = (r_state == S_MUL1) || (r_state == S_MUL2);
    assign mac_a = (r_state == S_MUL1) ? p_val : a_val;
    assign mac_b = (r_state == S_MUL1) ? w_s : wc_s;
    assign mac_acc = (r_state == S_MUL1) ? 64'sd0 : r_total;

    ictf_serial_mac #(.AW(32), .BW(18), .PW(64)) u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mac_start),
        .i_a(mac_a), .i_b(mac_b), .i_acc(mac_acc),
        .o_done(mac_done), .o_acc(mac_out)
    );

    // CORDIC step arithmetic.
    logic signed [26:0] xs, ys;
    logic [29:0] atv;
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign atv = 30'(atan_entry(r_i));

    // Restoring division step by D = 65536*4125 on the biased magnitude.
    localparam logic signed [63:0] Den = 64'sd270336000;
    logic signed [63:0] trial;
    assign trial = r_rem - (Den <<< r_dcnt);

    // Temperature numerator; its magnitude is divided and the sign put back at the end.
    logic signed [19:0] tnum_raw;
    logic tnum_neg;
    assign tnum_raw = 20'sd10 * 20'(r_tr) + 20'sd124202;
    assign tnum_neg = tnum_raw[19];

    // Temperature divide by 3400 in steps: quotient bit per cycle (8 bits).
    logic signed [19:0] ttrial;
    assign ttrial = r_tnum - (20'sd3400 <<< r_dcnt[2:0]);

    // Quotient with the bias of 2^DivTop removed, then saturated.
    logic signed [36:0] sat_in;
    logic signed [15:0] sat_out;
    assign sat_in = r_q - (37'sd1 <<< DivTop);
    assign sat_out = (sat_in > 37'sd32767) ? 16'sh7fff :
                     (sat_in < -37'sd32768) ? 16'sh8000 : 16'(sat_in);

    // The output register takes a new word once the previous one has been read.
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w <= BlendDefault;
            r_ang[0] <= '0; r_ang[1] <= '0; r_ang[2] <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_w <= i_cfg_data;
            if (out_load) r_ovalid <= 1'b1;
            else if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_samp.valid) begin
                        r_ax <= i_samp.accel_x; r_ay <= i_samp.accel_y;
                        r_az <= i_samp.accel_z; r_gx <= i_samp.gyro_x;
                        r_gy <= i_samp.gyro_y; r_gz <= i_samp.gyro_z;
                        r_tr <= i_samp.temp_raw; r_dt <= i_samp.elapsed_ms;
                        r_axis <= 2'd0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_i <= '0;
                    if (den < 0) begin
                        r_x <= -(27'(den) <<< 8); r_y <= -(27'(num) <<< 8);
                        r_z <= (num >= 0) ? 30'sd11796480 : -30'sd11796480;
                    end else begin
                        r_x <= 27'(den) <<< 8; r_y <= 27'(num) <<< 8; r_z <= '0;
                    end
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + $signed(atv);
                    end else begin
                        r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - $signed(atv);
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 5'(Steps - 1)) r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (num == 0 && den == 0) r_acc_ang <= '0;
                    else r_acc_ang <= 16'((r_z + 30'sd256) >>> 9);
                    r_state <= S_MUL1;
                end
                S_MUL1: r_state <= S_MUL1W;
                S_MUL1W: if (mac_done) begin r_total <= mac_out; r_state <= S_MUL2; end
                S_MUL2: r_state <= S_MUL2W;
                S_MUL2W: if (mac_done) begin
                    // floor((t + D/2)/D): bias to nonnegative by adding 2^DivTop * D.
                    r_rem <= mac_out + 64'sd135168000 + (Den <<< DivTop);
                    r_q <= '0;
                    r_dcnt <= 6'(DivTop);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (trial >= 0) begin
                        r_rem <= trial;
                        r_q <= r_q | (37'sd1 <<< r_dcnt);
                    end
                    if (r_dcnt == 6'd0) r_state <= S_NEXT;
                    else r_dcnt <= r_dcnt - 1'b1;
                end
                S_NEXT: begin
                    r_ang[r_axis] <= sat_out;
                    if (r_axis == 2'd2) begin
                        r_tnum <= tnum_neg ? -tnum_raw : tnum_raw;
                        r_tneg <= tnum_neg;
                        r_dcnt <= 6'd7;
                        r_tq <= '0;
                        r_state <= S_TEMP;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                        r_state <= S_PREP;
                    end
                end
                S_TEMP: begin
                    // The magnitude is divided, so the quotient truncates toward zero.
                    if (ttrial >= 0) begin
                        r_tnum <= ttrial;
                        r_tq <= r_tq | (9'sd1 <<< r_dcnt[2:0]);
                    end
                    if (r_dcnt == 6'd0) r_state <= S_OUT;
                    else r_dcnt <= r_dcnt - 1'b1;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_res[0] <= r_ang[0];
                        r_res[1] <= r_ang[1];
                        r_res[2] <= r_ang[2];
                        r_tdeg <= r_tneg ? -r_tq : r_tq;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_samp.ready  = (r_state == S_IDLE);
    assign o_res.valid   = r_ovalid;
    assign o_res.tilt_x  = r_res[0];
    assign o_res.tilt_y  = r_res[1];
    assign o_res.tilt_z  = r_res[2];
    assign o_res.temp_deg = r_tdeg;
endmodule
`default_nettype wire

@@ design/ictf_checker.sv @@
// Port-level checker for the tilt filter, bound to the top level.
`default_nettype none
module ictf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic signed [8:0] temp_deg
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result word dropped");
    a_no_accept_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("two words taken back to back");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result valid after reset");
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (temp_deg >= -9'sd60 && temp_deg <= 9'sd133))
        else $error("temperature out of range");
endmodule

bind imu_complementary_tilt_filter ictf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_samp.valid), .in_ready(i_samp.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .temp_deg(o_res.temp_deg)
);
`default_nettype wire
